// ===== hw/rtl/shuffle_bag_series_generator_macros.svh =====
// Assertion macros shared by the shuffle bag checker
`ifndef SHUFFLE_BAG_SERIES_GENERATOR_MACROS_SVH
`define SHUFFLE_BAG_SERIES_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SBSG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsg check failed");

// Next-cycle implication, disabled while in reset
`define SBSG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsg check failed");

`endif

// ===== hw/rtl/sbsg_pkg.sv =====
// Shared types, constants and command codes of the shuffle bag series generator
package sbsg_pkg;

    localparam int VALUE_W   = 16;
    localparam int MAX_ITEMS = 256;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CFG_W     = 16;
    localparam int RNG_W     = 16;
    localparam int FRAC_W    = 8;
    localparam int IDX_W     = 2;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 8'd128;
    localparam logic [RNG_W-1:0]  RNG_TAPS = 16'hB400;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAC  = 2'd2;
    localparam logic [IDX_W-1:0] REG_SEED  = 2'd3;

    typedef enum logic [1:0] {
        OP_NEXT    = 2'd0,
        OP_TOGGLE  = 2'd1,
        OP_RESTART = 2'd2,
        OP_IGNORE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_VALUE   = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REBUILT = 2'd2,
        ST_FULL    = 2'd3
    } st_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [VALUE_W-1:0] value_in;
    } in_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        st_t                       status;
        logic [CNT_W-1:0]          active_count;
    } out_rsp_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_FILL_INIT,
        CMD_FILL,
        CMD_BUILD_INIT,
        CMD_BUILD,
        CMD_BUILD_END,
        CMD_SH_SET_FULL,
        CMD_SH_SET_A,
        CMD_SH_SET_B,
        CMD_SH_DRAW,
        CMD_SH_READ,
        CMD_SH_W1,
        CMD_SH_W2,
        CMD_RESET_POS,
        CMD_RD_NEXT,
        CMD_SRCH_INIT,
        CMD_SRCH,
        CMD_MUTE_FLIP,
        CMD_INS_INIT,
        CMD_INS_MOVE,
        CMD_INS_PUT,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        st_t  status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic cfg_restart;
        logic idx_last;
        logic srch_go;
        logic found;
        logic full;
        logic ins_more;
        logic sh_more;
        logic empty;
        logic exhausted;
        logic keep_nz;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/sbsg_ctrl.sv =====
// Control state machine of the shuffle bag series generator
module sbsg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sbsg_pkg::dp_status_t   sts,
    output sbsg_pkg::ctrl_cmd_t    ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FILL,
        S_BUILD_INIT,
        S_BUILD,
        S_BUILD_END,
        S_SH_FULL,
        S_SH_CHECK,
        S_SH_READ,
        S_SH_W1,
        S_SH_W2,
        S_READ,
        S_RESULT,
        S_SRCH,
        S_TOGGLE,
        S_INS
    } state_t;

    typedef enum logic [1:0] {
        PH_FULL,
        PH_A,
        PH_B
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic          pend_reg, pend_next;
    logic          result_reg, result_next;
    sbsg_pkg::st_t res_reg, res_next;
    logic          pend_clr;

    assign in_ready = (state_reg == S_IDLE) && !pend_reg;
    assign pend_next = (pend_reg && !pend_clr) || sts.cfg_restart;

    // Next state and command decode
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        result_next = result_reg;
        res_next    = res_reg;
        pend_clr    = 1'b0;
        ctl.cmd     = sbsg_pkg::CMD_NONE;
        ctl.status  = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    ctl.cmd     = sbsg_pkg::CMD_FILL_INIT;
                    pend_clr    = 1'b1;
                    result_next = 1'b0;
                    state_next  = S_FILL;
                end
                else if (in_valid)
                begin
                    ctl.cmd    = sbsg_pkg::CMD_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    sbsg_pkg::OP_NEXT:
                    begin
                        if (sts.empty)
                        begin
                            res_next   = sbsg_pkg::ST_EMPTY;
                            state_next = S_RESULT;
                        end
                        else if (sts.exhausted)
                        begin
                            if (sts.keep_nz)
                            begin
                                ctl.cmd    = sbsg_pkg::CMD_SH_SET_A;
                                phase_next = PH_A;
                            end
                            else
                            begin
                                ctl.cmd    = sbsg_pkg::CMD_SH_SET_B;
                                phase_next = PH_B;
                            end
                            state_next = S_SH_CHECK;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    sbsg_pkg::OP_TOGGLE:
                    begin
                        ctl.cmd    = sbsg_pkg::CMD_SRCH_INIT;
                        state_next = S_SRCH;
                    end
                    sbsg_pkg::OP_RESTART:
                    begin
                        ctl.cmd     = sbsg_pkg::CMD_FILL_INIT;
                        result_next = 1'b1;
                        state_next  = S_FILL;
                    end
                    sbsg_pkg::OP_IGNORE:
                    begin
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILL:
            begin
                ctl.cmd = sbsg_pkg::CMD_FILL;
                if (sts.idx_last)
                    state_next = S_BUILD_INIT;
            end
            S_BUILD_INIT:
            begin
                ctl.cmd    = sbsg_pkg::CMD_BUILD_INIT;
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                ctl.cmd = sbsg_pkg::CMD_BUILD;
                if (sts.idx_last)
                    state_next = S_BUILD_END;
            end
            S_BUILD_END:
            begin
                ctl.cmd    = sbsg_pkg::CMD_BUILD_END;
                state_next = S_SH_FULL;
            end
            S_SH_FULL:
            begin
                ctl.cmd    = sbsg_pkg::CMD_SH_SET_FULL;
                phase_next = PH_FULL;
                state_next = S_SH_CHECK;
            end
            S_SH_CHECK:
            begin
                if (sts.sh_more)
                begin
                    ctl.cmd    = sbsg_pkg::CMD_SH_DRAW;
                    state_next = S_SH_READ;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_FULL:
                        begin
                            if (result_reg)
                            begin
                                res_next   = sbsg_pkg::ST_REBUILT;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        PH_A:
                        begin
                            ctl.cmd    = sbsg_pkg::CMD_SH_SET_B;
                            phase_next = PH_B;
                        end
                        PH_B:
                        begin
                            ctl.cmd    = sbsg_pkg::CMD_RESET_POS;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SH_READ:
            begin
                ctl.cmd    = sbsg_pkg::CMD_SH_READ;
                state_next = S_SH_W1;
            end
            S_SH_W1:
            begin
                ctl.cmd    = sbsg_pkg::CMD_SH_W1;
                state_next = S_SH_W2;
            end
            S_SH_W2:
            begin
                ctl.cmd    = sbsg_pkg::CMD_SH_W2;
                state_next = S_SH_CHECK;
            end
            S_READ:
            begin
                ctl.cmd    = sbsg_pkg::CMD_RD_NEXT;
                res_next   = sbsg_pkg::ST_VALUE;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.cmd    = sbsg_pkg::CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            S_SRCH:
            begin
                ctl.cmd = sbsg_pkg::CMD_SRCH;
                if (!sts.srch_go)
                    state_next = S_TOGGLE;
            end
            S_TOGGLE:
            begin
                if (sts.found)
                begin
                    ctl.cmd     = sbsg_pkg::CMD_MUTE_FLIP;
                    result_next = 1'b1;
                    state_next  = S_BUILD_INIT;
                end
                else if (sts.full)
                begin
                    res_next   = sbsg_pkg::ST_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.cmd    = sbsg_pkg::CMD_INS_INIT;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (sts.ins_more)
                begin
                    ctl.cmd = sbsg_pkg::CMD_INS_MOVE;
                end
                else
                begin
                    ctl.cmd     = sbsg_pkg::CMD_INS_PUT;
                    result_next = 1'b1;
                    state_next  = S_BUILD_INIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers; a rebuild is pending out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_FULL;
            pend_reg   <= 1'b1;
            result_reg <= 1'b0;
            res_reg    <= sbsg_pkg::ST_VALUE;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            result_reg <= result_next;
            res_reg    <= res_next;
        end
    end

endmodule

// ===== hw/rtl/sbsg_dp.sv =====
// Datapath: member and series memories, counters, LFSR and result register
module sbsg_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sbsg_pkg::ctrl_cmd_t                ctl,
    input  sbsg_pkg::in_req_t                  in_data,
    input  logic                               cfg_write,
    input  logic [sbsg_pkg::IDX_W-1:0]         cfg_index,
    input  logic [sbsg_pkg::CFG_W-1:0]         cfg_data,
    output sbsg_pkg::dp_status_t               sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sbsg_pkg::out_rsp_t                 out_data
);

    localparam int VW = sbsg_pkg::VALUE_W;
    localparam int AW = sbsg_pkg::ADDR_W;
    localparam int CW = sbsg_pkg::CNT_W;
    localparam int RW = sbsg_pkg::RNG_W;
    localparam int FW = sbsg_pkg::FRAC_W;
    localparam int SPAN_W = VW + 2;
    localparam logic [CW-1:0] CNT_MAX = CW'(sbsg_pkg::MAX_ITEMS);

    // Configuration and working registers
    logic signed [VW-1:0] lower_reg, upper_reg, base_reg, x_reg;
    logic [FW-1:0]        frac_reg;
    logic [RW-1:0]        rng_reg;
    sbsg_pkg::op_t        op_reg;
    logic [CW-1:0]        member_count_reg, series_count_reg, read_pos_reg, keep_reg;
    logic [CW-1:0]        idx_reg, i_reg, lo_reg, j_reg, wr_cnt_reg;
    logic                 out_valid_reg;
    sbsg_pkg::out_rsp_t   out_data_reg;

    // Memories
    logic [VW:0]   member_mem [sbsg_pkg::MAX_ITEMS];
    logic [VW-1:0] series_mem [sbsg_pkg::MAX_ITEMS];
    logic [VW:0]   member_rd_reg;
    logic [VW-1:0] series_rd_a_reg, series_rd_b_reg;

    logic          m_rd_en, m_we;
    logic [CW-1:0] m_rd_addr, m_wr_addr;
    logic [VW:0]   m_wr_data;
    logic          s_rd_en, s_rd_b_en, s_we;
    logic [CW-1:0] s_rd_addr_a, s_wr_addr;
    logic [VW-1:0] s_wr_data;

    logic signed [VW-1:0]  cfg_val, member_val;
    logic                  member_mute;
    logic signed [SPAN_W-1:0] span;
    logic [CW-1:0]         fill_n;
    logic [FW-1:0]         frac_sat;
    logic [FW+CW-1:0]      keep_prod;
    logic [RW-1:0]         rng_step;
    logic [CW-1:0]         draw_range;
    logic [RW+CW-1:0]      draw_prod;
    logic [CW-1:0]         idx_inc;
    logic                  idx_in;

    assign cfg_val     = cfg_data[VW-1:0];
    assign member_val  = member_rd_reg[VW-1:0];
    assign member_mute = member_rd_reg[VW];
    assign idx_inc     = idx_reg + 1'b1;
    assign idx_in      = idx_reg < member_count_reg;

    // Range size, clipped to the store depth
    assign span   = SPAN_W'(upper_reg) - SPAN_W'(lower_reg) + SPAN_W'(1);
    assign fill_n = (span > SPAN_W'(sbsg_pkg::MAX_ITEMS)) ? CNT_MAX : span[CW-1:0];

    // Guard count: saturated Q8 fraction times series length
    assign frac_sat  = (frac_reg > sbsg_pkg::FRAC_MAX) ? sbsg_pkg::FRAC_MAX : frac_reg;
    assign keep_prod = (FW+CW)'(frac_sat) * (FW+CW)'(wr_cnt_reg);

    // LFSR step and scaled draw in [lo, i]
    assign rng_step   = (rng_reg >> 1) ^ (rng_reg[0] ? sbsg_pkg::RNG_TAPS : '0);
    assign draw_range = i_reg - lo_reg + 1'b1;
    assign draw_prod  = (RW+CW)'(rng_step) * (RW+CW)'(draw_range);

    // Status toward the controller
    always_comb
    begin
        sts.op          = op_reg;
        sts.cfg_restart = cfg_write && (cfg_index != sbsg_pkg::REG_SEED);
        sts.idx_last    = idx_reg == (member_count_reg - 1'b1);
        sts.srch_go     = idx_in && (member_val < x_reg);
        sts.found       = idx_in && (member_val == x_reg);
        sts.full        = member_count_reg == CNT_MAX;
        sts.ins_more    = i_reg > idx_reg;
        sts.sh_more     = i_reg > lo_reg;
        sts.empty       = series_count_reg == '0;
        sts.exhausted   = read_pos_reg >= series_count_reg;
        sts.keep_nz     = keep_reg != '0;
        sts.out_busy    = out_valid_reg && !out_ready;
    end

    // Memory port control
    always_comb
    begin
        m_rd_en     = 1'b0;
        m_rd_addr   = '0;
        m_we        = 1'b0;
        m_wr_addr   = idx_reg;
        m_wr_data   = {1'b0, x_reg};
        s_rd_en     = 1'b0;
        s_rd_b_en   = 1'b0;
        s_rd_addr_a = i_reg;
        s_we        = 1'b0;
        s_wr_addr   = i_reg;
        s_wr_data   = series_rd_b_reg;
        unique case (ctl.cmd)
            sbsg_pkg::CMD_FILL:
            begin
                m_we      = 1'b1;
                m_wr_data = {1'b0, VW'(base_reg + $signed({1'b0, idx_reg}))};
            end
            sbsg_pkg::CMD_BUILD_INIT, sbsg_pkg::CMD_SRCH_INIT:
            begin
                m_rd_en = 1'b1;
            end
            sbsg_pkg::CMD_BUILD:
            begin
                m_rd_en   = 1'b1;
                m_rd_addr = idx_inc;
                s_we      = !member_mute;
                s_wr_addr = wr_cnt_reg;
                s_wr_data = member_val;
            end
            sbsg_pkg::CMD_SRCH:
            begin
                m_rd_en   = 1'b1;
                m_rd_addr = sts.srch_go ? idx_inc : idx_reg;
            end
            sbsg_pkg::CMD_MUTE_FLIP:
            begin
                m_we      = 1'b1;
                m_wr_data = {!member_mute, member_val};
            end
            sbsg_pkg::CMD_INS_INIT:
            begin
                m_rd_en   = 1'b1;
                m_rd_addr = member_count_reg - 1'b1;
            end
            sbsg_pkg::CMD_INS_MOVE:
            begin
                m_rd_en   = 1'b1;
                m_rd_addr = i_reg - CW'(2);
                m_we      = 1'b1;
                m_wr_addr = i_reg;
                m_wr_data = member_rd_reg;
            end
            sbsg_pkg::CMD_INS_PUT:
            begin
                m_we = 1'b1;
            end
            sbsg_pkg::CMD_SH_READ:
            begin
                s_rd_en   = 1'b1;
                s_rd_b_en = 1'b1;
            end
            sbsg_pkg::CMD_SH_W1:
            begin
                s_we = 1'b1;
            end
            sbsg_pkg::CMD_SH_W2:
            begin
                s_we      = 1'b1;
                s_wr_addr = j_reg;
                s_wr_data = series_rd_a_reg;
            end
            sbsg_pkg::CMD_RD_NEXT:
            begin
                s_rd_en     = 1'b1;
                s_rd_addr_a = read_pos_reg;
            end
            default:
            begin
                m_rd_en = 1'b0;
            end
        endcase
    end

    // Member store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (m_we)
            member_mem[m_wr_addr[AW-1:0]] <= m_wr_data;
        if (m_rd_en)
            member_rd_reg <= member_mem[m_rd_addr[AW-1:0]];
    end

    // Series store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (s_we)
            series_mem[s_wr_addr[AW-1:0]] <= s_wr_data;
        if (s_rd_en)
            series_rd_a_reg <= series_mem[s_rd_addr_a[AW-1:0]];
        if (s_rd_b_en)
            series_rd_b_reg <= series_mem[j_reg[AW-1:0]];
    end

    // Request operands, fill base and drawn swap index
    always_ff @(posedge clk)
    begin
        if (ctl.cmd == sbsg_pkg::CMD_CAPTURE)
        begin
            x_reg <= in_data.value_in;
        end
        if (ctl.cmd == sbsg_pkg::CMD_FILL_INIT)
            base_reg <= lower_reg;
        if (ctl.cmd == sbsg_pkg::CMD_SH_DRAW)
            j_reg <= lo_reg + draw_prod[RW +: CW];
    end

    // Configuration registers, bounds kept in order; LFSR and captured operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= VW'(15);
            frac_reg  <= '0;
            rng_reg   <= RW'(1);
            op_reg    <= sbsg_pkg::OP_IGNORE;
        end
        else
        begin
            if (ctl.cmd == sbsg_pkg::CMD_CAPTURE)
                op_reg <= in_data.operation;
            if (ctl.cmd == sbsg_pkg::CMD_SH_DRAW)
                rng_reg <= rng_step;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sbsg_pkg::REG_LOWER:
                    begin
                        if (cfg_val > upper_reg)
                        begin
                            lower_reg <= upper_reg;
                            upper_reg <= cfg_val;
                        end
                        else
                            lower_reg <= cfg_val;
                    end
                    sbsg_pkg::REG_UPPER:
                    begin
                        if (cfg_val < lower_reg)
                        begin
                            upper_reg <= lower_reg;
                            lower_reg <= cfg_val;
                        end
                        else
                            upper_reg <= cfg_val;
                    end
                    sbsg_pkg::REG_FRAC:
                        frac_reg <= cfg_data[FW-1:0];
                    sbsg_pkg::REG_SEED:
                        rng_reg <= (cfg_data[RW-1:0] == '0) ? RW'(1) : cfg_data[RW-1:0];
                    default:
                        frac_reg <= frac_reg;
                endcase
            end
        end
    end

    // Counters and loop indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= '0;
            series_count_reg <= '0;
            read_pos_reg     <= '0;
            keep_reg         <= '0;
            idx_reg          <= '0;
            i_reg            <= '0;
            lo_reg           <= '0;
            wr_cnt_reg       <= '0;
        end
        else
        begin
            unique case (ctl.cmd)
                sbsg_pkg::CMD_FILL_INIT:
                begin
                    member_count_reg <= fill_n;
                    idx_reg          <= '0;
                end
                sbsg_pkg::CMD_FILL:
                    idx_reg <= idx_inc;
                sbsg_pkg::CMD_BUILD_INIT:
                begin
                    idx_reg    <= '0;
                    wr_cnt_reg <= '0;
                end
                sbsg_pkg::CMD_BUILD:
                begin
                    idx_reg <= idx_inc;
                    if (!member_mute)
                        wr_cnt_reg <= wr_cnt_reg + 1'b1;
                end
                sbsg_pkg::CMD_BUILD_END:
                begin
                    series_count_reg <= wr_cnt_reg;
                    keep_reg         <= keep_prod[FW +: CW];
                    read_pos_reg     <= '0;
                end
                sbsg_pkg::CMD_SH_SET_FULL:
                begin
                    lo_reg <= '0;
                    i_reg  <= (series_count_reg == '0) ? '0 : series_count_reg - 1'b1;
                end
                sbsg_pkg::CMD_SH_SET_A:
                begin
                    lo_reg <= '0;
                    i_reg  <= series_count_reg - keep_reg - 1'b1;
                end
                sbsg_pkg::CMD_SH_SET_B:
                begin
                    lo_reg <= keep_reg;
                    i_reg  <= series_count_reg - 1'b1;
                end
                sbsg_pkg::CMD_SH_W2:
                    i_reg <= i_reg - 1'b1;
                sbsg_pkg::CMD_RESET_POS:
                    read_pos_reg <= '0;
                sbsg_pkg::CMD_RD_NEXT:
                    read_pos_reg <= read_pos_reg + 1'b1;
                sbsg_pkg::CMD_SRCH_INIT:
                    idx_reg <= '0;
                sbsg_pkg::CMD_SRCH:
                begin
                    if (sts.srch_go)
                        idx_reg <= idx_inc;
                end
                sbsg_pkg::CMD_INS_INIT:
                    i_reg <= member_count_reg;
                sbsg_pkg::CMD_INS_MOVE:
                    i_reg <= i_reg - 1'b1;
                sbsg_pkg::CMD_INS_PUT:
                    member_count_reg <= member_count_reg + 1'b1;
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    // Result register; a waiting result does not block new requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.cmd == sbsg_pkg::CMD_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == sbsg_pkg::CMD_OUT)
        begin
            out_data_reg.value_out    <= (ctl.status == sbsg_pkg::ST_VALUE) ?
                                         series_rd_a_reg : '0;
            out_data_reg.status       <= ctl.status;
            out_data_reg.active_count <= series_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/shuffle_bag_series_generator.sv =====
// Next request: capture, dispatch, read and result states; a new request is taken only back in
// idle. At the end of a pass the reshuffle adds a draw, a read and two writes per swap, the writes
// going through the one write port of the series memory.
// Toggle: a search, a shift when a value is inserted, a series build, then the shuffle.
// Restart or bound/fraction write: a fill, a series build and a full shuffle.
// Reset is asynchronous, active low; afterwards 0..15 is built and shuffled, with in_ready low.
module shuffle_bag_series_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sbsg_pkg::in_req_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sbsg_pkg::out_rsp_t             out_data,
    input  logic                           cfg_write,
    input  logic [sbsg_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sbsg_pkg::CFG_W-1:0]     cfg_data
);

    sbsg_pkg::ctrl_cmd_t  ctl;
    sbsg_pkg::dp_status_t sts;

    // Sequencer
    sbsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Memories, counters and result register
    sbsg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/sbsg_checker.sv =====
// Port-level checks of the shuffle bag series generator, bound to the top level
`include "shuffle_bag_series_generator_macros.svh"

module sbsg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input sbsg_pkg::out_rsp_t         out_data
);

    // A stalled result holds
    `SBSG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Only a given value carries a nonzero value field
    `SBSG_ASSERT_IMP(a_value_zero, out_valid && (out_data.status != sbsg_pkg::ST_VALUE), out_data.value_out == '0)

    // Empty status only with an empty series, a value only from a nonempty one
    `SBSG_ASSERT_IMP(a_empty_cnt, out_valid && (out_data.status == sbsg_pkg::ST_EMPTY), out_data.active_count == '0)
    `SBSG_ASSERT_IMP(a_value_cnt, out_valid && (out_data.status == sbsg_pkg::ST_VALUE), out_data.active_count != '0)

endmodule

bind shuffle_bag_series_generator sbsg_checker u_sbsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/tb_shuffle_bag_series_generator.sv =====
// Self-checking testbench for the shuffle bag series generator
`timescale 1ns / 1ps

module tb_shuffle_bag_series_generator;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_TICKS = 2000;
    localparam int VW           = sbsg_pkg::VALUE_W;
    localparam int CFGW         = sbsg_pkg::CFG_W;
    localparam int CNTW         = sbsg_pkg::CNT_W;
    localparam int RNGW         = sbsg_pkg::RNG_W;
    localparam int IDXW         = sbsg_pkg::IDX_W;
    localparam int MAXN         = sbsg_pkg::MAX_ITEMS;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sbsg_pkg::in_req_t  in_data;
    logic               out_valid;
    logic               out_ready;
    sbsg_pkg::out_rsp_t out_data;
    logic               cfg_write;
    logic [IDXW-1:0]    cfg_index;
    logic [CFGW-1:0]    cfg_data;

    shuffle_bag_series_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow copy of the bag state
    int              lower_reg;
    int              upper_reg;
    int              frac_reg;
    logic [RNGW-1:0] lfsr;
    int              mem_val [MAXN];
    bit              mem_mute [MAXN];
    int              member_cnt;
    int              series [MAXN];
    int              series_cnt;
    int              read_pos;
    int              keep_cnt;

    sbsg_pkg::in_req_t  request_queue [$];
    sbsg_pkg::out_rsp_t result_queue [$];
    int       err_count;
    bit       quiet;
    bit       stall_req;

    // LFSR step, then scale into [a,b]
    function automatic int draw_range(int a, int b);
        logic lsb;
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
        begin
            lfsr = lfsr ^ sbsg_pkg::RNG_TAPS;
        end
        return a + int'((longint'(lfsr) * longint'(b - a + 1)) >>> 16);
    endfunction

    function automatic void shuffle_span(int lo, int hi);
        int j;
        int t;
        for (int i = hi; i > lo; i--)
        begin
            j = draw_range(lo, i);
            t = series[i];
            series[i] = series[j];
            series[j] = t;
        end
    endfunction

    function automatic void rebuild_series();
        int f;
        f = (frac_reg > int'(sbsg_pkg::FRAC_MAX)) ? int'(sbsg_pkg::FRAC_MAX) : frac_reg;
        series_cnt = 0;
        for (int i = 0; i < member_cnt; i++)
        begin
            if (!mem_mute[i])
            begin
                series[series_cnt] = mem_val[i];
                series_cnt++;
            end
        end
        keep_cnt = (f * series_cnt) >> 8;
        read_pos = 0;
        shuffle_span(0, series_cnt - 1);
    endfunction

    function automatic void restart_range();
        int n;
        int t;
        if (upper_reg < lower_reg)
        begin
            t = upper_reg;
            upper_reg = lower_reg;
            lower_reg = t;
        end
        n = upper_reg - lower_reg + 1;
        if (n > MAXN)
        begin
            n = MAXN;
        end
        for (int i = 0; i < n; i++)
        begin
            mem_val[i]  = lower_reg + i;
            mem_mute[i] = 1'b0;
        end
        member_cnt = n;
        rebuild_series();
    endfunction

    function automatic void bag_config(logic [IDXW-1:0] idx, logic [CFGW-1:0] val);
        case (idx)
            sbsg_pkg::REG_LOWER:
            begin
                lower_reg = int'($signed(val));
                restart_range();
            end
            sbsg_pkg::REG_UPPER:
            begin
                upper_reg = int'($signed(val));
                restart_range();
            end
            sbsg_pkg::REG_FRAC:
            begin
                frac_reg = int'(val[sbsg_pkg::FRAC_W-1:0]);
                restart_range();
            end
            default:
            begin
                lfsr = (val == '0) ? RNGW'(1) : val[RNGW-1:0];
            end
        endcase
    endfunction

    // Works out the response of one request; returns 0 when none is due
    function automatic bit bag_predict(sbsg_pkg::in_req_t req, output sbsg_pkg::out_rsp_t rsp);
        sbsg_pkg::st_t st;
        int  v;
        int  x;
        int  pos;
        st = sbsg_pkg::ST_REBUILT;
        v  = 0;
        if (req.operation == sbsg_pkg::OP_IGNORE)
        begin
            rsp = '0;
            return 1'b0;
        end
        if (req.operation == sbsg_pkg::OP_NEXT)
        begin
            if (series_cnt == 0)
            begin
                st = sbsg_pkg::ST_EMPTY;
            end
            else
            begin
                if (read_pos >= series_cnt)
                begin
                    if (keep_cnt != 0)
                    begin
                        shuffle_span(0, series_cnt - keep_cnt - 1);
                    end
                    shuffle_span(keep_cnt, series_cnt - 1);
                    read_pos = 0;
                end
                v = series[read_pos];
                read_pos++;
                st = sbsg_pkg::ST_VALUE;
            end
        end
        else if (req.operation == sbsg_pkg::OP_TOGGLE)
        begin
            x = int'(req.value_in);
            pos = 0;
            while (pos < member_cnt && mem_val[pos] < x)
            begin
                pos++;
            end
            if (pos < member_cnt && mem_val[pos] == x)
            begin
                mem_mute[pos] = !mem_mute[pos];
                rebuild_series();
            end
            else if (member_cnt >= MAXN)
            begin
                st = sbsg_pkg::ST_FULL;
            end
            else
            begin
                for (int p = member_cnt; p > pos; p--)
                begin
                    mem_val[p]  = mem_val[p-1];
                    mem_mute[p] = mem_mute[p-1];
                end
                mem_val[pos]  = x;
                mem_mute[pos] = 1'b0;
                member_cnt++;
                rebuild_series();
            end
        end
        else
        begin
            restart_range();
        end
        rsp.value_out    = v[VW-1:0];
        rsp.status       = st;
        rsp.active_count = series_cnt[CNTW-1:0];
        return 1'b1;
    endfunction

    // Acceptance on both channels, checking and watchdog
    bit       in_taken;
    int       idle_ticks;
    always @(posedge clk)
    begin
        sbsg_pkg::out_rsp_t want;
        sbsg_pkg::out_rsp_t got;
        if (rst_n)
        begin
            idle_ticks++;
            if (in_valid && in_ready)
            begin
                idle_ticks = 0;
                in_taken = 1'b1;
                if (bag_predict(in_data, want))
                begin
                    result_queue.push_back(want);
                end
            end
            if (out_valid && out_ready)
            begin
                idle_ticks = 0;
                got = out_data;
                if (result_queue.size() == 0)
                begin
                    $error("unexpected response");
                    err_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got.value_out !== want.value_out)
                    begin
                        $error("value_out expected %0d actual %0d",
                               want.value_out, got.value_out);
                        err_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.active_count !== want.active_count)
                    begin
                        $error("active_count expected %0d actual %0d",
                               want.active_count, got.active_count);
                        err_count++;
                    end
                end
            end
            if (idle_ticks >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Request driver
    bit on_bus;
    int in_gap;
    always @(negedge clk)
    begin
        sbsg_pkg::in_req_t nxt;
        bit      load;
        load = 1'b0;
        if (in_taken)
        begin
            in_taken = 1'b0;
            on_bus   = 1'b0;
        end
        if (rst_n && !on_bus)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
            end
            else if (request_queue.size() > 0)
            begin
                nxt    = request_queue.pop_front();
                on_bus = 1'b1;
                load   = 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    in_gap = $urandom_range(1, 11);
                end
            end
        end
        in_valid <= on_bus;
        if (load)
        begin
            in_data <= nxt;
        end
    end

    // Response receiver with random and long stalls
    int out_gap;
    int long_hold;
    always @(negedge clk)
    begin
        if (stall_req)
        begin
            stall_req = 1'b0;
            long_hold = 300;
        end
        if (long_hold > 0)
        begin
            long_hold--;
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(1, 11);
            end
        end
    end

    task automatic push_req(sbsg_pkg::op_t op, logic [VW-1:0] v);
        sbsg_pkg::in_req_t r;
        r.operation = op;
        r.value_in  = v;
        request_queue.push_back(r);
    endtask

    // Wait until everything has been answered and the block has settled
    task automatic drain();
        while (request_queue.size() > 0 || on_bus || result_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDXW-1:0] idx, logic [CFGW-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        bag_config(idx, val);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Mostly next requests, toggles near the range, some restarts and noise
    task automatic push_random(int count);
        int r;
        logic [VW-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                push_req(sbsg_pkg::OP_NEXT, VW'($urandom));
            end
            else if (r < 90)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    v = VW'(lower_reg + int'($urandom_range(0, 30)) - 4);
                end
                else
                begin
                    v = VW'($urandom);
                end
                push_req(sbsg_pkg::OP_TOGGLE, v);
            end
            else if (r < 97)
            begin
                push_req(sbsg_pkg::OP_RESTART, VW'($urandom));
            end
            else
            begin
                push_req(sbsg_pkg::OP_IGNORE, VW'($urandom));
            end
        end
    endtask

    task automatic random_phase(int count);
        logic [CFGW-1:0] lo;
        lo = CFGW'($urandom);
        write_reg(sbsg_pkg::REG_SEED, CFGW'($urandom));
        write_reg(sbsg_pkg::REG_FRAC, CFGW'($urandom_range(0, 255)));
        write_reg(sbsg_pkg::REG_LOWER, lo);
        write_reg(sbsg_pkg::REG_UPPER, CFGW'(lo + CFGW'($urandom_range(0, 24))));
        push_random(count);
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        err_count = 0;
        quiet     = 1'b0;
        stall_req = 1'b0;
        lower_reg = 0;
        upper_reg = 15;
        frac_reg  = 0;
        lfsr      = RNGW'(1);
        restart_range();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default range: wrap past the series end, toggles at field extremes
        for (int i = 0; i < 18; i++)
        begin
            push_req(sbsg_pkg::OP_NEXT, '0);
        end
        push_req(sbsg_pkg::OP_IGNORE, 16'hFFFF);
        push_req(sbsg_pkg::OP_TOGGLE, 16'd5);
        push_req(sbsg_pkg::OP_TOGGLE, 16'h8000);
        push_req(sbsg_pkg::OP_TOGGLE, 16'h7FFF);
        push_req(sbsg_pkg::OP_RESTART, '0);
        push_req(sbsg_pkg::OP_NEXT, '0);
        drain();

        // Reversed bounds, saturated fraction, zero seed; long receiver stall
        write_reg(sbsg_pkg::REG_FRAC, 16'd255);
        write_reg(sbsg_pkg::REG_SEED, '0);
        write_reg(sbsg_pkg::REG_LOWER, 16'd10);
        write_reg(sbsg_pkg::REG_UPPER, 16'hFFFB);
        stall_req = 1'b1;
        push_random(100);
        drain();

        // Single member set: mute it and ask for a value from an empty series
        write_reg(sbsg_pkg::REG_LOWER, 16'd7);
        write_reg(sbsg_pkg::REG_UPPER, 16'd7);
        push_req(sbsg_pkg::OP_TOGGLE, 16'd7);
        push_req(sbsg_pkg::OP_NEXT, '0);
        push_req(sbsg_pkg::OP_TOGGLE, 16'd7);
        push_req(sbsg_pkg::OP_NEXT, '0);
        push_req(sbsg_pkg::OP_NEXT, '0);
        drain();

        // Oversized range fills the set; a new value is dropped
        write_reg(sbsg_pkg::REG_FRAC, 16'd128);
        write_reg(sbsg_pkg::REG_LOWER, 16'h8000);
        write_reg(sbsg_pkg::REG_UPPER, 16'h7FFF);
        push_req(sbsg_pkg::OP_TOGGLE, 16'd0);
        push_req(sbsg_pkg::OP_TOGGLE, 16'h8000);
        push_req(sbsg_pkg::OP_NEXT, '0);
        push_req(sbsg_pkg::OP_NEXT, '0);
        push_req(sbsg_pkg::OP_TOGGLE, 16'h8000);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            random_phase(80);
        end
        quiet = 1'b1;
        random_phase(60);

        while (result_queue.size() > 0)
        begin
            $error("response never arrived");
            err_count++;
            void'(result_queue.pop_front());
        end
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
